// File: src/sip_pkg.sv
// Shared constants and types for the segment intersection block.
package sip_pkg;

    localparam int SIP_PORT_BITS  = 32;
    localparam int SIP_COORD_BITS = 32;

    // Per-item status handed from the front end to the output side.
    typedef struct packed {
        logic hit;
        logic par;
        logic neg_x;
        logic neg_y;
    } t_sip_flags;

endpackage

// File: src/segment_intersection_point.sv
// Top level of the segment crossing test and crossing point unit.
// Usage: one request carries segment A (a_start -> a_end) and segment B
// (b_start -> b_end) as signed fixed-point coordinates; the low COORD_BITS
// bits of each port are used, sign-extended. Each request gives one result:
// hit, parallel_overlap and the crossing point, zero when there is no hit
// or on collinear overlap. Touching ends count as a hit.
// Both channels are valid/ready; a request moves when valid and ready are
// high at a rising edge.
// Pipeline: 7 front stages (input capture, differences and box test,
// products, cross terms, triple products, numerators, magnitudes),
// COORD_BITS+1 divider stages (one quotient bit each) and the output
// register. Throughput: one request per cycle while the pipe advances.
// The whole pipe advances together whenever the output register is empty
// or being taken; while the receiver holds ready low with a result waiting,
// every stage holds and o_ready is low. Nothing is lost or repeated.
// Reset (synchronous, active low) empties every stage.
module segment_intersection_point #(
    parameter int COORD_BITS = sip_pkg::SIP_COORD_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]  i_a_start_x,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]  i_a_start_y,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]  i_a_end_x,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]  i_a_end_y,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]  i_b_start_x,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]  i_b_start_y,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]  i_b_end_x,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]  i_b_end_y,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_hit,
    output logic                               o_parallel_overlap,
    output logic [sip_pkg::SIP_PORT_BITS-1:0]  o_cross_x,
    output logic [sip_pkg::SIP_PORT_BITS-1:0]  o_cross_y
);
    import sip_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int QB = C + 1;
    localparam int NW = 3 * C + 5;
    localparam int DW = 2 * C + 3;
    localparam int PB = SIP_PORT_BITS;

    logic                 en;
    logic                 f_valid;
    t_sip_flags           f_flags;
    logic [NW-1:0]        f_num_x, f_num_y;
    logic [DW-1:0]        f_den;
    logic signed [C+1:0]  quo_x, quo_y;

    logic [QB-1:0]        r_fvld;
    logic                 r_fhit [QB];
    logic                 r_fpar [QB];

    logic                 r_out_valid;
    logic                 r_hit, r_par;
    logic [PB-1:0]        r_x, r_y;
    logic                 pt_ok;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    sip_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_x1    (i_a_start_x),
        .i_y1    (i_a_start_y),
        .i_x2    (i_a_end_x),
        .i_y2    (i_a_end_y),
        .i_x3    (i_b_start_x),
        .i_y3    (i_b_start_y),
        .i_x4    (i_b_end_x),
        .i_y4    (i_b_end_y),
        .o_valid (f_valid),
        .o_flags (f_flags),
        .o_num_x (f_num_x),
        .o_num_y (f_num_y),
        .o_den   (f_den)
    );

    sip_div #(.COORD_BITS(COORD_BITS)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (f_num_x),
        .i_den (f_den),
        .i_neg (f_flags.neg_x),
        .o_quo (quo_x)
    );

    sip_div #(.COORD_BITS(COORD_BITS)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (f_num_y),
        .i_den (f_den),
        .i_neg (f_flags.neg_y),
        .o_quo (quo_y)
    );

    // flags ride alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld      <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_fvld      <= {r_fvld[QB-2:0], f_valid};
            r_out_valid <= r_fvld[QB-1];
        end
    end

    assign pt_ok = r_fhit[QB-1] && !r_fpar[QB-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fhit[0] <= f_flags.hit;
            r_fpar[0] <= f_flags.par;
            for (int k = 1; k < QB; k++) begin
                r_fhit[k] <= r_fhit[k-1];
                r_fpar[k] <= r_fpar[k-1];
            end
            r_hit <= r_fhit[QB-1];
            r_par <= r_fpar[QB-1];
            r_x   <= pt_ok ? PB'(quo_x) : '0;
            r_y   <= pt_ok ? PB'(quo_y) : '0;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_hit              = r_hit;
    assign o_parallel_overlap = r_par;
    assign o_cross_x          = r_x;
    assign o_cross_y          = r_y;

    a_par_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_parallel_overlap |-> o_hit)
        else $error("overlap flag without hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_cross_x == '0 && o_cross_y == '0 && !o_parallel_overlap)
        else $error("miss result not cleared");

    a_par_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_parallel_overlap |-> o_cross_x == '0 && o_cross_y == '0)
        else $error("overlap result carries a point");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

// File: src/sip_front.sv
// Front end: box test, cross products, denominators, numerators and their magnitudes.
module sip_front #(
    parameter int COORD_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]    i_x1,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]    i_y1,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]    i_x2,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]    i_y2,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]    i_x3,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]    i_y3,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]    i_x4,
    input  logic [sip_pkg::SIP_PORT_BITS-1:0]    i_y4,
    output logic                                 o_valid,
    output sip_pkg::t_sip_flags                  o_flags,
    output logic [3*COORD_BITS+4:0]              o_num_x,
    output logic [3*COORD_BITS+4:0]              o_num_y,
    output logic [2*COORD_BITS+2:0]              o_den
);
    import sip_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int W1 = C + 1;
    localparam int W2 = 2 * C + 2;
    localparam int W3 = 3 * C + 3;
    localparam int DW = 2 * C + 3;
    localparam int NW = 3 * C + 5;
    localparam int NS = 7;

    logic [NS-1:0] r_vld;

    // stage 1: sign-extended coordinates
    logic signed [C-1:0] r_x1, r_y1, r_x2, r_y2, r_x3, r_y3, r_x4, r_y4;

    // stage 2: differences and box rejection
    logic signed [W1-1:0] r_dxa, r_dya, r_dxb, r_dyb;
    logic signed [W1-1:0] r_ex13, r_ey13, r_ex23, r_ey23, r_ex41, r_ey41;
    logic signed [W1-1:0] r_ey12, r_ey34, r_ex12, r_ex42, r_ex34;
    logic signed [W1-1:0] r_px1, r_px3, r_py2, r_py4;
    logic                 r_miss2;

    // stage 3: pair products
    logic signed [W2-1:0] r_m1, r_m2, r_m3, r_m4, r_m5, r_m6, r_m7, r_m8;
    logic signed [W2-1:0] r_m9, r_m10, r_m11, r_m12, r_m13, r_m14, r_m15;
    logic signed [W1-1:0] r_dxa3, r_dya3, r_dxb3, r_dyb3, r_ey12_3;
    logic                 r_miss3;

    // stage 4: cross products, denominator, split partial products
    logic signed [DW-1:0] r_c1, r_c2, r_c3, r_c4, r_den4;
    logic signed [W2:0]   r_pl [6];
    logic signed [W2-1:0] r_ph [6];
    logic                 r_miss4;
    logic signed [W2-1:0] v_arr [6];
    logic signed [W1-1:0] w_arr [6];

    // stage 5: triple products and decision
    logic signed [W3-1:0] r_tp [6];
    logic signed [DW-1:0] r_den5;
    logic                 r_hit5, r_par5;
    logic                 s12_same, s34_same;

    // stage 6: numerators
    logic signed [NW-1:0] r_nx, r_ny;
    logic signed [DW-1:0] r_den6;
    logic                 r_hit6, r_par6;

    // stage 7: magnitudes
    logic [NW-1:0]        r_nx_mag, r_ny_mag;
    logic [DW-1:0]        r_den_mag;
    t_sip_flags           r_flags;

    logic ax_lt_b, ay_lt_b, bx_lt_a, by_lt_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    assign ax_lt_b = (r_x1 < r_x3) && (r_x1 < r_x4) && (r_x2 < r_x3) && (r_x2 < r_x4);
    assign ay_lt_b = (r_y1 < r_y3) && (r_y1 < r_y4) && (r_y2 < r_y3) && (r_y2 < r_y4);
    assign bx_lt_a = (r_x3 < r_x1) && (r_x3 < r_x2) && (r_x4 < r_x1) && (r_x4 < r_x2);
    assign by_lt_a = (r_y3 < r_y1) && (r_y3 < r_y2) && (r_y4 < r_y1) && (r_y4 < r_y2);

    always_comb begin
        v_arr[0] = r_m2;  w_arr[0] = r_dxa3;
        v_arr[1] = r_m11; w_arr[1] = r_dxa3;
        v_arr[2] = r_m12; w_arr[2] = r_dxb3;
        v_arr[3] = r_m13; w_arr[3] = r_dyb3;
        v_arr[4] = r_m14; w_arr[4] = r_ey12_3;
        v_arr[5] = r_m15; w_arr[5] = r_dya3;
    end

    assign s12_same = (r_c1 != '0) && (r_c2 != '0) && (r_c1[DW-1] == r_c2[DW-1]);
    assign s34_same = (r_c3 != '0) && (r_c4 != '0) && (r_c3[DW-1] == r_c4[DW-1]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1
            r_x1 <= $signed(i_x1[C-1:0]);
            r_y1 <= $signed(i_y1[C-1:0]);
            r_x2 <= $signed(i_x2[C-1:0]);
            r_y2 <= $signed(i_y2[C-1:0]);
            r_x3 <= $signed(i_x3[C-1:0]);
            r_y3 <= $signed(i_y3[C-1:0]);
            r_x4 <= $signed(i_x4[C-1:0]);
            r_y4 <= $signed(i_y4[C-1:0]);

            // stage 2
            r_dxa  <= W1'(r_x2) - W1'(r_x1);
            r_dya  <= W1'(r_y2) - W1'(r_y1);
            r_dxb  <= W1'(r_x4) - W1'(r_x3);
            r_dyb  <= W1'(r_y4) - W1'(r_y3);
            r_ex13 <= W1'(r_x1) - W1'(r_x3);
            r_ey13 <= W1'(r_y1) - W1'(r_y3);
            r_ex23 <= W1'(r_x2) - W1'(r_x3);
            r_ey23 <= W1'(r_y2) - W1'(r_y3);
            r_ex41 <= W1'(r_x4) - W1'(r_x1);
            r_ey41 <= W1'(r_y4) - W1'(r_y1);
            r_ey12 <= W1'(r_y1) - W1'(r_y2);
            r_ey34 <= W1'(r_y3) - W1'(r_y4);
            r_ex12 <= W1'(r_x1) - W1'(r_x2);
            r_ex42 <= W1'(r_x4) - W1'(r_x2);
            r_ex34 <= W1'(r_x3) - W1'(r_x4);
            r_px1  <= W1'(r_x1);
            r_px3  <= W1'(r_x3);
            r_py2  <= W1'(r_y2);
            r_py4  <= W1'(r_y4);
            r_miss2 <= ax_lt_b || ay_lt_b || bx_lt_a || by_lt_a;

            // stage 3
            r_m1  <= r_ex13 * r_dyb;
            r_m2  <= r_ey13 * r_dxb;
            r_m3  <= r_ex23 * r_dyb;
            r_m4  <= r_ey23 * r_dxb;
            r_m5  <= r_ex13 * r_dya;
            r_m6  <= r_ey13 * r_dxa;
            r_m7  <= r_ex41 * r_dya;
            r_m8  <= r_ey41 * r_dxa;
            r_m9  <= r_dxb * r_ey12;
            r_m10 <= r_dxa * r_ey34;
            r_m11 <= r_px3 * r_dyb;
            r_m12 <= r_px1 * r_dya;
            r_m13 <= r_py2 * r_ex12;
            r_m14 <= r_ex42 * r_dyb;
            r_m15 <= r_py4 * r_ex34;
            r_dxa3   <= r_dxa;
            r_dya3   <= r_dya;
            r_dxb3   <= r_dxb;
            r_dyb3   <= r_dyb;
            r_ey12_3 <= r_ey12;
            r_miss3  <= r_miss2;

            // stage 4: third cross uses the reversed vector, so its sign is flipped
            r_c1    <= DW'(r_m1) - DW'(r_m2);
            r_c2    <= DW'(r_m3) - DW'(r_m4);
            r_c3    <= DW'(r_m6) - DW'(r_m5);
            r_c4    <= DW'(r_m7) - DW'(r_m8);
            r_den4  <= DW'(r_m9) - DW'(r_m10);
            r_miss4 <= r_miss3;
            for (int k = 0; k < 6; k++) begin
                r_pl[k] <= $signed({1'b0, v_arr[k][C:0]}) * w_arr[k];
                r_ph[k] <= $signed(v_arr[k][W2-1:C+1]) * w_arr[k];
            end

            // stage 5
            for (int k = 0; k < 6; k++) begin
                r_tp[k] <= (W3'(r_ph[k]) <<< (C + 1)) + W3'(r_pl[k]);
            end
            r_den5 <= r_den4;
            r_hit5 <= !r_miss4 && !s12_same && !s34_same;
            r_par5 <= !r_miss4 && !s12_same && !s34_same && (r_den4 == '0);

            // stage 6
            r_nx   <= NW'(r_tp[0]) + NW'(r_tp[1]) - NW'(r_tp[2]);
            r_ny   <= NW'(r_tp[3]) + NW'(r_tp[4]) - NW'(r_tp[5]);
            r_den6 <= r_den5;
            r_hit6 <= r_hit5;
            r_par6 <= r_par5;

            // stage 7: y divides by the negated denominator
            r_nx_mag      <= r_nx[NW-1] ? NW'(-r_nx) : NW'(r_nx);
            r_ny_mag      <= r_ny[NW-1] ? NW'(-r_ny) : NW'(r_ny);
            r_den_mag     <= r_den6[DW-1] ? DW'(-r_den6) : DW'(r_den6);
            r_flags.hit   <= r_hit6;
            r_flags.par   <= r_par6;
            r_flags.neg_x <= r_nx[NW-1] ^ r_den6[DW-1];
            r_flags.neg_y <= r_ny[NW-1] ^ !r_den6[DW-1];
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_flags = r_flags;
    assign o_num_x = r_nx_mag;
    assign o_num_y = r_ny_mag;
    assign o_den   = r_den_mag;

endmodule

// File: src/sip_div.sv
// Pipelined restoring divider: one quotient bit per stage, signed result.
module sip_div #(
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [3*COORD_BITS+4:0]      i_num,
    input  logic [2*COORD_BITS+2:0]      i_den,
    input  logic                         i_neg,
    output logic signed [COORD_BITS+1:0] o_quo
);
    localparam int C  = COORD_BITS;
    localparam int QB = C + 1;
    localparam int DW = 2 * C + 3;

    logic [DW-1:0] r_rem  [QB];
    logic [QB-1:0] r_bits [QB];
    logic [QB-1:0] r_quo  [QB];
    logic [DW-1:0] r_den  [QB];
    logic          r_neg  [QB];

    logic [DW-1:0] p_rem  [QB];
    logic [QB-1:0] p_bits [QB];
    logic [QB-1:0] p_quo  [QB];
    logic [DW-1:0] p_den  [QB];
    logic          p_neg  [QB];

    logic [DW:0]   trial  [QB];
    logic          ge     [QB];

    // quotient magnitude is below 2^QB, so the top part starts below the divisor
    always_comb begin
        p_rem[0]  = i_num[QB+DW-1:QB];
        p_bits[0] = i_num[QB-1:0];
        p_quo[0]  = '0;
        p_den[0]  = i_den;
        p_neg[0]  = i_neg;
        for (int k = 1; k < QB; k++) begin
            p_rem[k]  = r_rem[k-1];
            p_bits[k] = r_bits[k-1];
            p_quo[k]  = r_quo[k-1];
            p_den[k]  = r_den[k-1];
            p_neg[k]  = r_neg[k-1];
        end
        for (int k = 0; k < QB; k++) begin
            trial[k] = {p_rem[k], p_bits[k][QB-1]};
            ge[k]    = trial[k] >= {1'b0, p_den[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QB; k++) begin
                r_rem[k]  <= ge[k] ? DW'(trial[k] - {1'b0, p_den[k]}) : DW'(trial[k]);
                r_bits[k] <= {p_bits[k][QB-2:0], 1'b0};
                r_quo[k]  <= {p_quo[k][QB-2:0], ge[k]};
                r_den[k]  <= p_den[k];
                r_neg[k]  <= p_neg[k];
            end
        end
    end

    assign o_quo = r_neg[QB-1] ? -$signed({1'b0, r_quo[QB-1]})
                               :  $signed({1'b0, r_quo[QB-1]});

endmodule
